FILE: src/c402es_pkg.sv
`timescale 1ns / 1ps
// Package for the CiA 402 drive enable sequencer.
// Holds command and result codes, object constants and the result bundle type.
package c402es_pkg;

    typedef enum logic [2:0] {
        CMD_STATUS  = 3'd0,
        CMD_FAULT   = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_TARGET  = 3'd4,
        CMD_TIMEOUT = 3'd5,
        CMD_QUERY   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SDO_READ  = 2'd0,
        KIND_SDO_WRITE = 2'd1,
        KIND_COMMAND   = 2'd2,
        KIND_REPLY     = 2'd3
    } kind_t;

    localparam logic CFG_POSITION_MODE = 1'b0;
    localparam logic CFG_NODE_ADDRESS  = 1'b1;

    localparam logic [6:0]  NODE_RESET     = 7'd2;
    localparam logic [10:0] SDO_BASE_ID    = 11'h600;
    localparam logic [10:0] CMD_BASE_ID    = 11'h200;
    localparam logic [15:0] OBJ_ERROR_CODE = 16'h603F;
    localparam logic [15:0] OBJ_BATT_CLEAR = 16'h2F21;
    localparam logic [15:0] TIMEOUT_CODE   = 16'hFFFF;

    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_NEW_SETPT   = 16'h003F;

    localparam logic [3:0] ST_NOT_READY = 4'd0;
    localparam logic [3:0] ST_READY     = 4'd1;
    localparam logic [3:0] ST_SWITCHED  = 4'd3;
    localparam logic [3:0] ST_OPERATION = 4'd7;

    localparam logic [2:0] FAULT_COUNT_MAX = 3'd6;
    localparam logic [2:0] FAULT_COUNT_LIM = 3'd5;

    localparam logic [1:0] TS_OK       = 2'd0;
    localparam logic [1:0] TS_NOT_OPER = 2'd1;
    localparam logic [1:0] TS_FAULTED  = 2'd2;

    // Pending words of one bundle: error-code read, battery clear, final word
    localparam int SLOT_READ  = 0;
    localparam int SLOT_WRITE = 1;
    localparam int SLOT_FINAL = 2;

    typedef struct packed {
        logic [2:0]         mask;
        logic               reply;
        logic [6:0]         node;
        logic [15:0]        ctrl;
        logic signed [31:0] target;
        logic [15:0]        fault_report;
        logic [1:0]         tstatus;
        logic signed [31:0] position;
        logic               oper;
    } bundle_t;

    function automatic logic known_code(input logic [15:0] code);
        unique case (code)
            16'h2340, 16'h3120, 16'h3333, 16'h4310, 16'h5280, 16'h5281,
            16'h5400, 16'h5441, 16'h6180, 16'h6181, 16'h6320, 16'h7121,
            16'h7300, 16'h7380, 16'h8130, 16'h8311, 16'h8380, 16'h8381:
                known_code = 1'b1;
            default: known_code = 1'b0;
        endcase
    endfunction

endpackage

FILE: src/c402es_core.sv
`timescale 1ns / 1ps
// Input register, drive state and one-pass step logic of the sequencer.
// Depends on c402es_pkg; hands a result bundle to c402es_emit.
module c402es_core import c402es_pkg::*; #(
    parameter int STARTUP_DELAY_TICKS = 150,
    parameter int POLL_PERIOD         = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [15:0]        status_word,
    input  logic signed [31:0] feedback_position,
    input  logic [15:0]        fault_bytes,
    input  logic signed [31:0] target_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    output logic               item_valid,
    input  logic               item_take,
    output bundle_t            bundle
);

    logic               item_valid_reg;
    logic [2:0]         cmd_reg;
    logic [15:0]        status_reg;
    logic signed [31:0] fbpos_reg;
    logic [15:0]        fbytes_reg;
    logic signed [31:0] tval_reg;

    logic               pos_mode_reg;
    logic [6:0]         node_reg;

    logic               drive_en_reg,   drive_en_next;
    logic               frp_reg,        frp_next;
    logic               latched_reg,    latched_next;
    logic [15:0]        fcode_reg,      fcode_next;
    logic [5:0]         phase_reg,      phase_next;
    logic [2:0]         ffc_reg,        ffc_next;
    logic [7:0]         delay_reg,      delay_next;
    logic               oper_reg,       oper_next;
    logic               toggle_reg,     toggle_next;
    logic [15:0]        ctrl_reg,       ctrl_next;
    logic signed [31:0] setpt_reg,      setpt_next;
    logic signed [31:0] pos_reg,        pos_next;

    logic [3:0] dstate;
    logic       faulted;
    logic [6:0] phase_inc;

    assign cfg_ready  = 1'b1;
    assign item_valid = item_valid_reg;
    assign in_ready   = !item_valid_reg || item_take;
    assign dstate     = status_reg[3:0];
    assign faulted    = status_reg[3];
    assign phase_inc  = {1'b0, phase_reg} + 7'd1;

    always_comb
    begin
        drive_en_next = drive_en_reg;
        frp_next      = frp_reg;
        latched_next  = latched_reg;
        fcode_next    = fcode_reg;
        phase_next    = phase_reg;
        ffc_next      = ffc_reg;
        delay_next    = delay_reg;
        oper_next     = oper_reg;
        toggle_next   = toggle_reg;
        ctrl_next     = ctrl_reg;
        setpt_next    = setpt_reg;
        pos_next      = pos_reg;
        bundle        = '0;
        bundle.node   = node_reg;

        unique case (cmd_reg)
            CMD_STATUS:
            begin
                pos_next = fbpos_reg;
                if (faulted && frp_reg)
                begin
                    ctrl_next  = CW_FAULT_RESET;
                    setpt_next = '0;
                end
                else
                begin
                    frp_next = 1'b0;
                end
                if (drive_en_reg && !frp_next)
                begin
                    if (delay_reg != 8'd0)
                        delay_next = delay_reg - 8'd1;
                    if (dstate == ST_NOT_READY)
                        ctrl_next = CW_SHUTDOWN;
                    else if (dstate == ST_READY)
                        ctrl_next = CW_SWITCH_ON;
                    else if (dstate == ST_SWITCHED)
                        ctrl_next = CW_ENABLE_OP;
                    else if (dstate != ST_OPERATION)
                        drive_en_next = 1'b0;
                end
                oper_next = (dstate == ST_OPERATION);
                if (pos_mode_reg && oper_next)
                begin
                    ctrl_next   = toggle_reg ? CW_ENABLE_OP : CW_NEW_SETPT;
                    toggle_next = !toggle_reg;
                end
                if (!drive_en_next && !frp_next)
                    ctrl_next = '0;
                if (faulted)
                begin
                    bundle.mask[SLOT_READ]  = (phase_reg == 6'd1);
                    bundle.mask[SLOT_WRITE] = 1'b1;
                    phase_next = (phase_inc >= 7'(POLL_PERIOD)) ? 6'd0 : phase_inc[5:0];
                    if (ffc_reg < FAULT_COUNT_MAX)
                        ffc_next = ffc_reg + 3'd1;
                end
                else
                begin
                    phase_next   = '0;
                    ffc_next     = '0;
                    latched_next = 1'b0;
                end
                if (ffc_next > FAULT_COUNT_LIM)
                    latched_next = 1'b1;
                bundle.mask[SLOT_FINAL] = 1'b1;
                bundle.ctrl   = ctrl_next;
                bundle.target = setpt_next;
            end
            CMD_FAULT:
            begin
                if (known_code(fbytes_reg))
                    fcode_next = fbytes_reg;
            end
            CMD_ENABLE:
            begin
                delay_next    = 8'(STARTUP_DELAY_TICKS);
                frp_next      = 1'b1;
                drive_en_next = 1'b1;
            end
            CMD_DISABLE: drive_en_next = 1'b0;
            CMD_TARGET:  setpt_next = tval_reg;
            CMD_TIMEOUT:
            begin
                latched_next = 1'b1;
                fcode_next   = TIMEOUT_CODE;
            end
            CMD_QUERY: ;
            default: ;
        endcase

        // Every command but a status frame answers with one reply word
        if (cmd_reg != CMD_STATUS && cmd_reg <= CMD_QUERY)
        begin
            bundle.mask[SLOT_FINAL] = 1'b1;
            bundle.reply        = 1'b1;
            bundle.fault_report = latched_next ? fcode_next : 16'd0;
            if (latched_next)
                bundle.tstatus = TS_FAULTED;
            else if (!oper_next && delay_next == 8'd0)
                bundle.tstatus = TS_NOT_OPER;
            else
                bundle.tstatus = TS_OK;
            bundle.position = pos_next;
            bundle.oper     = oper_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg    <= cmd;
            status_reg <= status_word;
            fbpos_reg  <= feedback_position;
            fbytes_reg <= fault_bytes;
            tval_reg   <= target_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_mode_reg <= 1'b0;
            node_reg     <= NODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POSITION_MODE)
                pos_mode_reg <= cfg_data[0];
            else
                node_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_en_reg <= 1'b0;
            frp_reg      <= 1'b0;
            latched_reg  <= 1'b0;
            fcode_reg    <= '0;
            phase_reg    <= '0;
            ffc_reg      <= '0;
            delay_reg    <= '0;
            oper_reg     <= 1'b0;
            toggle_reg   <= 1'b0;
            ctrl_reg     <= '0;
            setpt_reg    <= '0;
            pos_reg      <= '0;
        end
        else if (item_valid_reg && item_take)
        begin
            drive_en_reg <= drive_en_next;
            frp_reg      <= frp_next;
            latched_reg  <= latched_next;
            fcode_reg    <= fcode_next;
            phase_reg    <= phase_next;
            ffc_reg      <= ffc_next;
            delay_reg    <= delay_next;
            oper_reg     <= oper_next;
            toggle_reg   <= toggle_next;
            ctrl_reg     <= ctrl_next;
            setpt_reg    <= setpt_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

FILE: src/c402es_emit.sv
`timescale 1ns / 1ps
// Result register of the sequencer: holds one bundle and sends its words in order.
// Depends on c402es_pkg.
module c402es_emit import c402es_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_take,
    input  bundle_t            bundle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         item_kind,
    output logic [10:0]        frame_id,
    output logic [15:0]        control_word,
    output logic signed [31:0] target_out,
    output logic [15:0]        sdo_index,
    output logic [7:0]         sdo_subindex,
    output logic [31:0]        sdo_value,
    output logic [15:0]        fault_report,
    output logic [1:0]         target_status,
    output logic signed [31:0] position_out,
    output logic               is_operational,
    output logic               last
);

    bundle_t    res_reg;
    logic [2:0] mask_reg, mask_next;
    logic       final_only;
    logic       pop;

    assign final_only = (mask_reg == 3'b100);
    assign out_valid  = (mask_reg != 3'b000);
    assign pop        = out_valid && out_ready;
    assign item_take  = item_valid && (!out_valid || (pop && final_only));
    assign last       = final_only;

    always_comb
    begin
        if (item_take)
            mask_next = bundle.mask;
        else if (pop)
            mask_next = mask_reg & (mask_reg - 3'd1);
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            res_reg <= bundle;
    end

    always_comb
    begin
        item_kind      = KIND_COMMAND;
        frame_id       = '0;
        control_word   = '0;
        target_out     = '0;
        sdo_index      = '0;
        sdo_subindex   = '0;
        sdo_value      = '0;
        fault_report   = '0;
        target_status  = '0;
        position_out   = '0;
        is_operational = 1'b0;
        if (mask_reg[SLOT_READ])
        begin
            item_kind = KIND_SDO_READ;
            frame_id  = SDO_BASE_ID + {4'd0, res_reg.node};
            sdo_index = OBJ_ERROR_CODE;
        end
        else if (mask_reg[SLOT_WRITE])
        begin
            item_kind    = KIND_SDO_WRITE;
            frame_id     = SDO_BASE_ID + {4'd0, res_reg.node};
            sdo_index    = OBJ_BATT_CLEAR;
            sdo_subindex = 8'd1;
            sdo_value    = 32'd1;
        end
        else if (res_reg.reply)
        begin
            item_kind      = KIND_REPLY;
            fault_report   = res_reg.fault_report;
            target_status  = res_reg.tstatus;
            position_out   = res_reg.position;
            is_operational = res_reg.oper;
        end
        else
        begin
            item_kind    = KIND_COMMAND;
            frame_id     = CMD_BASE_ID + {4'd0, res_reg.node};
            control_word = res_reg.ctrl;
            target_out   = res_reg.target;
        end
    end

endmodule

FILE: src/cia402_drive_enable_sequencer.sv
`timescale 1ns / 1ps
// CiA 402 drive enable sequencer: host side of one servo drive on CANopen.
// An accepted word goes through the core input register, then the result register.
// Throughput: one input word per cycle for single-reply commands while out_ready
// is high; a status frame holds the result register for its one to three words.
// Reset clears all drive state; position_mode resets to 0, node_address to 2.
module cia402_drive_enable_sequencer import c402es_pkg::*; #(
    parameter int STARTUP_DELAY_TICKS = 150,
    parameter int POLL_PERIOD         = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [15:0]        status_word,
    input  logic signed [31:0] feedback_position,
    input  logic [15:0]        fault_bytes,
    input  logic signed [31:0] target_value,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         item_kind,
    output logic [10:0]        frame_id,
    output logic [15:0]        control_word,
    output logic signed [31:0] target_out,
    output logic [15:0]        sdo_index,
    output logic [7:0]         sdo_subindex,
    output logic [31:0]        sdo_value,
    output logic [15:0]        fault_report,
    output logic [1:0]         target_status,
    output logic signed [31:0] position_out,
    output logic               is_operational,
    output logic               last
);

    // The core holds the accepted word and the drive state. When the result
    // register is free (empty, or sending its final word this cycle) the core
    // commits its state update and hands over the whole result bundle at once.
    logic    item_valid;
    logic    item_take;
    bundle_t bundle;

    c402es_core #(
        .STARTUP_DELAY_TICKS (STARTUP_DELAY_TICKS),
        .POLL_PERIOD         (POLL_PERIOD)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .status_word       (status_word),
        .feedback_position (feedback_position),
        .fault_bytes       (fault_bytes),
        .target_value      (target_value),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_take         (item_take),
        .bundle            (bundle)
    );

    // The emitter sends the pending words in order: error-code read, battery
    // clear, then the command frame or reply, which carries last.
    c402es_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .bundle         (bundle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .frame_id       (frame_id),
        .control_word   (control_word),
        .target_out     (target_out),
        .sdo_index      (sdo_index),
        .sdo_subindex   (sdo_subindex),
        .sdo_value      (sdo_value),
        .fault_report   (fault_report),
        .target_status  (target_status),
        .position_out   (position_out),
        .is_operational (is_operational),
        .last           (last)
    );

endmodule

FILE: tb/sv/cia402_drive_enable_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for cia402_drive_enable_sequencer, built on c402es_pkg.
// A scoreboard class predicts every result word of the drive sequencer; tasks
// drive input and configuration, a process drives out_ready, with random idling.
module cia402_drive_enable_sequencer_test;
    import c402es_pkg::*;

    localparam int          STARTUP_TICKS = 150;   // startup delay of the block
    localparam int          POLL_PERIOD   = 50;    // faulted frames per error poll
    localparam int          DRAIN_CYCLES  = 10;    // quiet cycles after the last result
    localparam int          ITEM_GOAL     = 330;   // random words to offer
    localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam logic [2:0]  CMD_UNUSED    = 3'd7;  // code the block ignores

    // One result word as seen on the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] frame_id;
        logic [15:0] ctrl;
        logic [31:0] target;
        logic [15:0] sdo_index;
        logic [7:0]  sdo_sub;
        logic [31:0] sdo_value;
        logic [15:0] fault_report;
        logic [1:0]  tstatus;
        logic [31:0] position;
        logic        oper;
        logic        last;
    } can_frame_t;

    // Scoreboard: tracks drive state, predicts the frames and replies of each
    // accepted word and checks them in order against the result channel.
    class drive_frame_ledger;
        can_frame_t  due_frames[$];
        logic [15:0] drive_codes[18];
        int          errors;
        int          words_in;
        int          frames_out;
        int          reads_seen;
        int          latched_replies;
        int          cfg_writes;
        // configuration
        logic        pos_mode;
        logic [6:0]  node;
        // drive state
        logic        enable_req;
        logic        reset_pending;
        logic        fault_latched;
        logic        oper_flag;
        logic        toggle;
        logic [15:0] fault_code;
        logic [15:0] ctrl_store;
        logic [31:0] setpt_store;
        logic [31:0] pos_store;
        int          poll_phase;
        int          fault_frames;
        int          delay_left;

        function new();
            drive_codes = '{16'h2340, 16'h3120, 16'h3333, 16'h4310, 16'h5280, 16'h5281,
                            16'h5400, 16'h5441, 16'h6180, 16'h6181, 16'h6320, 16'h7121,
                            16'h7300, 16'h7380, 16'h8130, 16'h8311, 16'h8380, 16'h8381};
            errors = 0; words_in = 0; frames_out = 0;
            reads_seen = 0; latched_replies = 0; cfg_writes = 0;
            pos_mode = 1'b0; node = NODE_RESET;
            enable_req = 1'b0; reset_pending = 1'b0; fault_latched = 1'b0;
            oper_flag = 1'b0; toggle = 1'b0;
            fault_code = '0; ctrl_store = '0; setpt_store = '0; pos_store = '0;
            poll_phase = 0; fault_frames = 0; delay_left = 0;
        endfunction

        function can_frame_t blank_frame(logic [1:0] k, logic [10:0] id);
            can_frame_t f;
            f = '0;
            f.kind = k;
            f.frame_id = id;
            return f;
        endfunction

        function void queue_reply();
            can_frame_t f;
            f = blank_frame(KIND_REPLY, '0);
            if (fault_latched)
                f.tstatus = TS_FAULTED;
            else if (!oper_flag && delay_left == 0)
                f.tstatus = TS_NOT_OPER;
            else
                f.tstatus = TS_OK;
            f.fault_report = fault_latched ? fault_code : 16'h0000;
            f.position = pos_store;
            f.oper = oper_flag;
            f.last = 1'b1;
            if (fault_latched)
                latched_replies++;
            due_frames.push_back(f);
        endfunction

        function void step_status(logic [15:0] sw, logic [31:0] pos);
            logic [3:0] st;
            logic       faulted;
            can_frame_t f;
            st = sw[3:0];
            faulted = sw[3];
            pos_store = pos;
            if (faulted && reset_pending) begin
                ctrl_store = CW_FAULT_RESET;
                setpt_store = '0;
            end
            else
                reset_pending = 1'b0;
            if (enable_req && !reset_pending) begin
                if (delay_left > 0)
                    delay_left--;
                if (st == ST_NOT_READY)
                    ctrl_store = CW_SHUTDOWN;
                else if (st == ST_READY)
                    ctrl_store = CW_SWITCH_ON;
                else if (st == ST_SWITCHED)
                    ctrl_store = CW_ENABLE_OP;
                else if (st != ST_OPERATION)
                    enable_req = 1'b0;
            end
            oper_flag = (st == ST_OPERATION);
            if (pos_mode && oper_flag) begin
                ctrl_store = toggle ? CW_ENABLE_OP : CW_NEW_SETPT;
                toggle = !toggle;
            end
            if (!enable_req && !reset_pending)
                ctrl_store = '0;
            if (faulted) begin
                if (poll_phase == 1) begin
                    f = blank_frame(KIND_SDO_READ, SDO_BASE_ID + node);
                    f.sdo_index = OBJ_ERROR_CODE;
                    due_frames.push_back(f);
                    reads_seen++;
                end
                poll_phase = (poll_phase + 1 >= POLL_PERIOD) ? 0 : poll_phase + 1;
                if (fault_frames < FAULT_COUNT_MAX)
                    fault_frames++;
                f = blank_frame(KIND_SDO_WRITE, SDO_BASE_ID + node);
                f.sdo_index = OBJ_BATT_CLEAR;
                f.sdo_sub = 8'd1;
                f.sdo_value = 32'd1;
                due_frames.push_back(f);
            end
            else begin
                poll_phase = 0;
                fault_frames = 0;
                fault_latched = 1'b0;
            end
            if (fault_frames > FAULT_COUNT_LIM)
                fault_latched = 1'b1;
            f = blank_frame(KIND_COMMAND, CMD_BASE_ID + node);
            f.ctrl = ctrl_store;
            f.target = setpt_store;
            f.last = 1'b1;
            due_frames.push_back(f);
        endfunction

        function void log_request(logic [2:0] c, logic [15:0] sw, logic [31:0] pos,
                                  logic [15:0] fb, logic [31:0] tv);
            words_in++;
            case (c)
                CMD_STATUS:
                    step_status(sw, pos);
                CMD_FAULT: begin
                    foreach (drive_codes[i])
                        if (drive_codes[i] == fb)
                            fault_code = fb;
                    queue_reply();
                end
                CMD_ENABLE: begin
                    delay_left = STARTUP_TICKS;
                    reset_pending = 1'b1;
                    enable_req = 1'b1;
                    queue_reply();
                end
                CMD_DISABLE: begin
                    enable_req = 1'b0;
                    queue_reply();
                end
                CMD_TARGET: begin
                    setpt_store = tv;
                    queue_reply();
                end
                CMD_TIMEOUT: begin
                    fault_latched = 1'b1;
                    fault_code = TIMEOUT_CODE;
                    queue_reply();
                end
                CMD_QUERY:
                    queue_reply();
                default: ;
            endcase
        endfunction

        function void note_config(logic idx, logic [6:0] data);
            cfg_writes++;
            if (idx == CFG_POSITION_MODE)
                pos_mode = data[0];
            else
                node = data;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_frame(can_frame_t got);
            can_frame_t want;
            frames_out++;
            if (due_frames.size() == 0) begin
                $display("%0t ns: result word with nothing expected, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = due_frames.pop_front();
            compare("item_kind", 32'(want.kind), 32'(got.kind));
            compare("frame_id", 32'(want.frame_id), 32'(got.frame_id));
            compare("control_word", 32'(want.ctrl), 32'(got.ctrl));
            compare("target_out", want.target, got.target);
            compare("sdo_index", 32'(want.sdo_index), 32'(got.sdo_index));
            compare("sdo_subindex", 32'(want.sdo_sub), 32'(got.sdo_sub));
            compare("sdo_value", want.sdo_value, got.sdo_value);
            compare("fault_report", 32'(want.fault_report), 32'(got.fault_report));
            compare("target_status", 32'(want.tstatus), 32'(got.tstatus));
            compare("position_out", want.position, got.position);
            compare("is_operational", 32'(want.oper), 32'(got.oper));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic [15:0]        status_word;
    logic signed [31:0] feedback_position;
    logic [15:0]        fault_bytes;
    logic signed [31:0] target_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [6:0]         cfg_data;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         item_kind;
    logic [10:0]        frame_id;
    logic [15:0]        control_word;
    logic signed [31:0] target_out;
    logic [15:0]        sdo_index;
    logic [7:0]         sdo_subindex;
    logic [31:0]        sdo_value;
    logic [15:0]        fault_report;
    logic [1:0]         target_status;
    logic signed [31:0] position_out;
    logic               is_operational;
    logic               last;

    drive_frame_ledger ledger = new();

    int sender_idle_pct = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct  = 0;   // chance per cycle that the receiver stalls
    int hold_left       = 0;   // remaining cycles of a long receiver hold-off
    int items_sent      = 0;   // accepted words that the block acts on

    cia402_drive_enable_sequencer uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .status_word       (status_word),
        .feedback_position (feedback_position),
        .fault_bytes       (fault_bytes),
        .target_value      (target_value),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .item_kind         (item_kind),
        .frame_id          (frame_id),
        .control_word      (control_word),
        .target_out        (target_out),
        .sdo_index         (sdo_index),
        .sdo_subindex      (sdo_subindex),
        .sdo_value         (sdo_value),
        .fault_report      (fault_report),
        .target_status     (target_status),
        .position_out      (position_out),
        .is_operational    (is_operational),
        .last              (last)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: drive out_ready at the falling edge. A pending hold-off wins
    // over the random stall so the block backs up and stalls its input.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sample every accepted result word at the rising edge.
    always @(posedge clk) begin
        can_frame_t got;
        if (rst_n && out_valid && out_ready) begin
            got.kind = item_kind;
            got.frame_id = frame_id;
            got.ctrl = control_word;
            got.target = target_out;
            got.sdo_index = sdo_index;
            got.sdo_sub = sdo_subindex;
            got.sdo_value = sdo_value;
            got.fault_report = fault_report;
            got.tstatus = target_status;
            got.position = position_out;
            got.oper = is_operational;
            got.last = last;
            ledger.check_frame(got);
        end
    end

    // Offer one word; hold valid and payload until the block takes it. Valid
    // stays high past acceptance so back-to-back words never drop it.
    task automatic send_word(logic [2:0] c, logic [15:0] sw, logic [31:0] pos,
                             logic [15:0] fb, logic [31:0] tv);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        status_word = sw;
        feedback_position = pos;
        fault_bytes = fb;
        target_value = tv;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.log_request(c, sw, pos, fb, tv);
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    // Drop valid, wait for every expected word, then let an ignored word finish.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (ledger.due_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.note_config(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random 16-bit field value
    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Status word with random upper bits and the given low nibble
    function automatic logic [15:0] word_with_state(logic [3:0] st);
        logic [15:0] r;
        r = rand16();
        return {r[15:4], st};
    endfunction

    task automatic status_frame(logic [3:0] st);
        send_word(CMD_STATUS, word_with_state(st), $urandom, rand16(), $urandom);
    endtask

    // A faulted run, a fault code, maybe a timeout, a query and maybe a clean frame
    task automatic fault_burst(int n);
        repeat (n) status_frame(4'($urandom_range(8, 15)));
        if ($urandom_range(1))
            send_word(CMD_FAULT, rand16(), $urandom, ledger.drive_codes[$urandom_range(17)],
                      $urandom);
        else
            send_word(CMD_FAULT, rand16(), $urandom, rand16(), $urandom);
        if ($urandom_range(3) == 0)
            send_word(CMD_TIMEOUT, rand16(), $urandom, rand16(), $urandom);
        send_word(CMD_QUERY, rand16(), $urandom, rand16(), $urandom);
        if ($urandom_range(3) != 0)
            status_frame(4'($urandom_range(0, 7)));
    endtask

    // Well-formed enable sequence: enable, optional fault reset, shutdown,
    // switch on, enable operation, then operational frames with setpoints.
    task automatic power_up(bit long_run);
        int op_frames;
        send_word(CMD_ENABLE, rand16(), $urandom, rand16(), $urandom);
        if ($urandom_range(1))
            status_frame(4'($urandom_range(8, 15)));
        repeat ($urandom_range(1, 2)) status_frame(ST_NOT_READY);
        repeat ($urandom_range(1, 2)) status_frame(ST_READY);
        repeat ($urandom_range(1, 2)) status_frame(ST_SWITCHED);
        op_frames = long_run ? STARTUP_TICKS + 5 : $urandom_range(1, 20);
        repeat (op_frames) begin
            case ($urandom_range(9))
                0: send_word(CMD_TARGET, rand16(), $urandom, rand16(), $urandom);
                1: send_word(CMD_QUERY, rand16(), $urandom, rand16(), $urandom);
                default: status_frame(ST_OPERATION);
            endcase
        end
        if (long_run) begin
            // run the delay out, then leave operation so the query reports it
            while (ledger.delay_left > 0)
                status_frame(ST_OPERATION);
            status_frame(ST_READY);
            send_word(CMD_QUERY, rand16(), $urandom, rand16(), $urandom);
        end
        case ($urandom_range(3))
            0: send_word(CMD_DISABLE, rand16(), $urandom, rand16(), $urandom);
            1: status_frame(4'($urandom_range(4, 6)));
            2: fault_burst($urandom_range(1, 8));
            default: ;
        endcase
    endtask

    // Noise: any code, the ignored one too, with random fields
    task automatic noise();
        repeat ($urandom_range(1, 6))
            send_word(3'($urandom_range(7)), rand16(), $urandom, rand16(), $urandom);
    endtask

    initial begin
        int phase;
        int pick;
        int rand_base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_QUERY;
        status_word = '0;
        feedback_position = '0;
        fault_bytes = '0;
        target_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POSITION_MODE;
        cfg_data = '0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with reset configuration: every command, field extremes,
        // stored and ignored fault codes, timeout latch, fault reset, the full
        // enable ladder and a three-word status frame.
        send_word(CMD_QUERY, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
        send_word(CMD_STATUS, 16'h0000, 32'h8000_0000, 16'h0000, 32'h0000_0000);
        send_word(CMD_FAULT, 16'h0000, 32'h0, 16'h2340, 32'h0);
        send_word(CMD_FAULT, 16'h0000, 32'h0, 16'hFFFF, 32'h0);
        send_word(CMD_TIMEOUT, 16'h0000, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_QUERY, 16'h0000, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0000, 32'h0000_0001, 16'h0000, 32'h0);
        send_word(CMD_FAULT, 16'h0000, 32'h0, 16'h8381, 32'h0);
        send_word(CMD_TARGET, 16'h0000, 32'h0, 16'h0000, 32'h7FFF_FFFF);
        send_word(CMD_ENABLE, 16'h0000, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0008, 32'h0000_0000, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0000, 32'h1234_5678, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0001, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0003, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0007, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_TARGET, 16'h0000, 32'h0, 16'h0000, 32'h8000_0000);
        send_word(CMD_STATUS, 16'hFFF7, 32'h7FFF_FFFF, 16'h0000, 32'h0);
        send_word(CMD_QUERY, 16'h0000, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_STATUS, 16'h0005, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_DISABLE, 16'h0000, 32'h0, 16'h0000, 32'h0);
        send_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);

        rand_base = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            settle();
            // Reconfigure only while the block is idle
            case (phase)
                0: begin
                    sender_idle_pct = 0;  recv_stall_pct = 0;
                    write_reg(CFG_POSITION_MODE, 7'd1);
                    write_reg(CFG_NODE_ADDRESS, 7'd127);
                end
                1: begin
                    sender_idle_pct = 45; recv_stall_pct = 0;
                    write_reg(CFG_POSITION_MODE, 7'd0);
                    write_reg(CFG_NODE_ADDRESS, 7'd1);
                end
                2: begin
                    sender_idle_pct = 0;  recv_stall_pct = 45;
                    write_reg(CFG_POSITION_MODE, 7'd1);
                    write_reg(CFG_NODE_ADDRESS, 7'($urandom_range(1, 127)));
                end
                default: begin
                    sender_idle_pct = 29; recv_stall_pct = 29;
                    write_reg(CFG_POSITION_MODE, 7'($urandom_range(1)));
                    write_reg(CFG_NODE_ADDRESS, 7'($urandom_range(1, 127)));
                end
            endcase
            // Phase openers: back up the block, run out the startup delay,
            // and wrap the error poll with a long faulted stretch.
            if (phase == 0) begin
                hold_left = HOLD_CYCLES;
                power_up(1'b0);
            end
            else if (phase == 1)
                power_up(1'b1);
            else if (phase == 2)
                fault_burst(POLL_PERIOD + 3);
            while (items_sent - rand_base < ITEM_GOAL * (phase + 1) / 4) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    power_up(1'b0);
                else if (pick < 75)
                    fault_burst(($urandom_range(7) == 0) ? $urandom_range(POLL_PERIOD, 56)
                                                         : $urandom_range(1, 8));
                else
                    noise();
            end
        end
        settle();

        $display("summary: %0d input words, %0d result words checked, %0d config writes",
                 ledger.words_in, ledger.frames_out, ledger.cfg_writes);
        $display("summary: %0d error-code reads, %0d replies with a latched fault",
                 ledger.reads_seen, ledger.latched_replies);
        if (ledger.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
